// ===== rtl/smli_pkg.sv =====
// Shared types and constants of the serial line multiplexer.
// Used by the controller, the datapath and the top level; no dependencies.
package smli_pkg;

  typedef enum logic [2:0] {
    REQ_READ  = 3'd0,
    REQ_WRITE = 3'd1,
    REQ_RX    = 3'd2,
    REQ_CONN  = 3'd3,
    REQ_RETRY = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    REG_CSR  = 2'd0,
    REG_RBUF = 2'd1,
    REG_TCR  = 2'd2,
    REG_MSR  = 2'd3
  } reg_e;

  // CSR bit positions
  localparam int unsigned CSR_MAINT = 3;
  localparam int unsigned CSR_CLR   = 4;
  localparam int unsigned CSR_MSE   = 5;
  localparam int unsigned CSR_RIE   = 6;
  localparam int unsigned CSR_RDONE = 7;
  localparam int unsigned CSR_TLO   = 8;
  localparam int unsigned CSR_THI   = 10;
  localparam int unsigned CSR_SAE   = 12;
  localparam int unsigned CSR_SA    = 13;
  localparam int unsigned CSR_TIE   = 14;
  localparam int unsigned CSR_TRDY  = 15;

  localparam logic [15:0] CSR_WMASK = 16'h5068; // TIE SAE RIE MSE MAINT
  localparam int unsigned LPR_RXON  = 12;
  localparam logic [15:0] SILO_VALID = 16'h8000;
  localparam logic [15:0] SILO_FRM   = 16'h2000;
  localparam logic [6:0]  ALARM_MAX  = 7'd127;

  typedef struct packed {
    logic capture;
    logic fetch;
    logic exec;
    logic scan;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic out_stall;
  } sts_t;

  function automatic logic [15:0] merge16(input logic [15:0] cur, input logic [15:0] data,
                                          input logic odd, input logic bytew);
    logic [15:0] r;
    if (!bytew) r = data;
    else if (odd) r = {data[15:8], cur[7:0]};
    else r = {cur[15:8], data[7:0]};
    return r;
  endfunction

endpackage

// ===== rtl/smli_if.sv =====
// Request and response channel interfaces of the serial line multiplexer.
// Depends on nothing; valid/ready handshake plus payload fields.
interface smli_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [2:0]  reg_offset;
  logic        byte_access;
  logic [15:0] write_data;
  logic [2:0]  line_number;
  logic [7:0]  rx_char;
  logic        rx_break;
  logic        line_connected;
  logic        link_ready;
  modport source (output valid, req_type, reg_offset, byte_access, write_data, line_number,
                  rx_char, rx_break, line_connected, link_ready, input ready);
  modport sink (input valid, req_type, reg_offset, byte_access, write_data, line_number,
                rx_char, rx_break, line_connected, link_ready, output ready);
endinterface

interface smli_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic        tx_valid;
  logic [2:0]  tx_line;
  logic [7:0]  tx_char;
  logic        rx_accepted;
  logic        rx_irq;
  logic        tx_irq;
  logic [7:0]  dtr_lines;
  modport source (output valid, read_data, tx_valid, tx_line, tx_char, rx_accepted, rx_irq,
                  tx_irq, dtr_lines, input ready);
  modport sink (input valid, read_data, tx_valid, tx_line, tx_char, rx_accepted, rx_irq,
                tx_irq, dtr_lines, output ready);
endinterface

// ===== rtl/smli_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smli_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/smli_ctrl.sv =====
// Sequencer of the serial line multiplexer: capture, silo fetch, execute, scan, deliver.
// Depends on smli_pkg.
module smli_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  smli_pkg::sts_t sts_i,
  output smli_pkg::cmd_t cmd_o
);
  typedef enum logic [2:0] {
    ST_IDLE, ST_FETCH, ST_EXEC, ST_SCAN, ST_DONE
  } state_e;

  state_e state_q;

  assign req_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o         = '0;
    cmd_o.capture = (state_q == ST_IDLE) && req_valid_i;
    cmd_o.fetch   = (state_q == ST_FETCH);
    cmd_o.exec    = (state_q == ST_EXEC);
    cmd_o.scan    = (state_q == ST_SCAN);
    cmd_o.load    = (state_q == ST_DONE) && !sts_i.out_stall;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE:  if (req_valid_i) state_q <= ST_FETCH;
        ST_FETCH: state_q <= ST_EXEC;
        ST_EXEC:  state_q <= ST_SCAN;
        ST_SCAN:  state_q <= ST_DONE;
        ST_DONE:  if (!sts_i.out_stall) state_q <= ST_IDLE;
        default:  state_q <= ST_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/smli_dp.sv =====
// Datapath of the serial line multiplexer: registers, receive silo, line scan, result.
// Depends on smli_pkg, smli_if and smli_ram.
module smli_dp #(
  parameter int unsigned SILO_DEPTH  = 64,
  parameter int unsigned ALARM_LEVEL = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  smli_req_if.sink       req_i,
  smli_rsp_if.source     rsp_o,
  input  smli_pkg::cmd_t cmd_i,
  output smli_pkg::sts_t sts_o
);
  localparam int unsigned PW = $clog2(SILO_DEPTH);
  localparam logic [PW-1:0] PTR_LAST = PW'(SILO_DEPTH - 1);
  localparam logic [6:0] ALARM_LIM = 7'(ALARM_LEVEL);

  // captured transaction
  logic [2:0]  req_q, off_q, ln_q;
  logic        bytew_q, brk_q, conn_in_q, rdy_q;
  logic [15:0] data_q;
  logic [7:0]  ch_q;

  // unit state
  logic [15:0]   csr_q, csr_d;
  logic [PW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [6:0]    alarm_q, alarm_d;
  logic [7:0]    len_q, len_d, dtr_q, dtr_d, rxon_q, rxon_d, ring_q, ring_d, conn_q, conn_d;
  logic [7:0]    hflag_q, hflag_d;
  logic [7:0]    hchar_q [8];
  logic          rxirq_q, rxirq_d, txirq_q, txirq_d;

  // per-transaction results
  logic [15:0] rd_q, rd_d;
  logic        txv_q, txv_d, acc_q, acc_d, scan_q, scan_d;
  logic [2:0]  txl_q, txl_d;
  logic [7:0]  txc_q, txc_d;

  logic        hwe;
  logic [2:0]  hidx;
  logic [7:0]  hsel;
  logic        swe;
  logic [15:0] swdata, srdata;
  logic        out_valid_q;

  smli_ram #(.WIDTH(16), .DEPTH(SILO_DEPTH)) u_silo (
    .clk_i   (clk_i),
    .we_i    (swe),
    .waddr_i (wp_q),
    .wdata_i (swdata),
    .re_i    (cmd_i.fetch),
    .raddr_i (rp_q),
    .rdata_o (srdata)
  );

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  assign sts_o.out_stall = out_valid_q && !rsp_o.ready;

  // single held-character read port: retry uses the request line, other requests the scanned line
  assign hidx = (req_q == smli_pkg::REQ_RETRY) ? ln_q : csr_q[smli_pkg::CSR_THI:smli_pkg::CSR_TLO];
  assign hsel = hchar_q[hidx];

  always_comb begin
    logic [1:0]  rsel;
    logic        odd;
    logic [15:0] v;
    logic [2:0]  t;
    logic [2:0]  l;
    logic [2:0]  start;
    logic        found;
    logic [2:0]  pick;
    csr_d = csr_q;   wp_d = wp_q;     rp_d = rp_q;     alarm_d = alarm_q;
    len_d = len_q;   dtr_d = dtr_q;   rxon_d = rxon_q; ring_d = ring_q;
    conn_d = conn_q; hflag_d = hflag_q;
    rxirq_d = rxirq_q; txirq_d = txirq_q;
    rd_d = rd_q; txv_d = txv_q; txl_d = txl_q; txc_d = txc_q; acc_d = acc_q; scan_d = scan_q;
    hwe = 1'b0; swe = 1'b0;
    swdata = '0;
    rsel = off_q[2:1];
    odd = off_q[0];
    v = '0;
    t = csr_q[smli_pkg::CSR_THI:smli_pkg::CSR_TLO];
    l = '0; start = '0; found = 1'b0; pick = '0;

    if (cmd_i.exec) begin
      rd_d = '0; txv_d = 1'b0; txl_d = '0; txc_d = '0; acc_d = 1'b0; scan_d = 1'b1;
      unique case (req_q)
        smli_pkg::REQ_READ: begin
          scan_d = 1'b0;
          unique case (rsel)
            smli_pkg::REG_CSR: rd_d = csr_q;
            smli_pkg::REG_RBUF: begin
              if (csr_q[smli_pkg::CSR_MSE]) begin
                csr_d[smli_pkg::CSR_SA] = 1'b0;
                csr_d[smli_pkg::CSR_RDONE] = 1'b0;
                rxirq_d = 1'b0;
                if (wp_q != rp_q) begin
                  rd_d = srdata;
                  rp_d = ptr_inc(rp_q);
                  alarm_d = '0;
                end
                if (wp_q != rp_d) begin
                  csr_d[smli_pkg::CSR_RDONE] = 1'b1;
                  if (csr_q[smli_pkg::CSR_RIE]) rxirq_d = 1'b1;
                end
              end
            end
            smli_pkg::REG_TCR: rd_d = {dtr_q, len_q};
            default: begin
              rd_d = {conn_q, ring_q};
              ring_d = '0;
            end
          endcase
        end
        smli_pkg::REQ_WRITE: begin
          unique case (rsel)
            smli_pkg::REG_CSR: begin
              v = smli_pkg::merge16(csr_q, data_q, odd, bytew_q);
              if (v[smli_pkg::CSR_CLR]) begin
                csr_d = '0; wp_d = '0; rp_d = '0; alarm_d = '0; len_d = '0;
                rxirq_d = 1'b0; txirq_d = 1'b0; scan_d = 1'b0;
              end else begin
                csr_d = (csr_q & ~(smli_pkg::CSR_WMASK | 16'(1 << smli_pkg::CSR_CLR)))
                        | (v & smli_pkg::CSR_WMASK);
                rxirq_d = (csr_d[smli_pkg::CSR_RDONE] && csr_d[smli_pkg::CSR_RIE])
                          || (csr_d[smli_pkg::CSR_SA] && csr_d[smli_pkg::CSR_SAE]);
                txirq_d = csr_d[smli_pkg::CSR_TRDY] && csr_d[smli_pkg::CSR_TIE];
              end
            end
            smli_pkg::REG_RBUF: rxon_d[data_q[2:0]] = data_q[smli_pkg::LPR_RXON];
            smli_pkg::REG_TCR: begin
              v = smli_pkg::merge16({dtr_q, len_q}, data_q, odd, bytew_q);
              csr_d[smli_pkg::CSR_TRDY] = 1'b0;
              len_d = v[7:0];
              dtr_d = v[15:8];
              txirq_d = 1'b0;
            end
            default: begin
              if (!(bytew_q && odd) && csr_q[smli_pkg::CSR_TRDY]) begin
                if (len_q[t] && conn_q[t]) begin
                  if (rdy_q) begin
                    txv_d = 1'b1; txl_d = t; txc_d = data_q[7:0];
                  end else begin
                    hflag_d[t] = 1'b1;
                    hwe = 1'b1;
                  end
                end
                csr_d[smli_pkg::CSR_TRDY] = 1'b0;
                txirq_d = 1'b0;
              end
            end
          endcase
        end
        smli_pkg::REQ_RX: begin
          if (rxon_q[ln_q] && (ptr_inc(wp_q) != rp_q)) begin
            swe = 1'b1;
            swdata = brk_q ? (smli_pkg::SILO_VALID | smli_pkg::SILO_FRM | {5'd0, ln_q, 8'd0})
                           : (smli_pkg::SILO_VALID | {5'd0, ln_q, ch_q});
            wp_d = ptr_inc(wp_q);
            if (alarm_q != smli_pkg::ALARM_MAX) alarm_d = alarm_q + 7'd1;
            acc_d = 1'b1;
            csr_d[smli_pkg::CSR_RDONE] = 1'b1;
            if (csr_q[smli_pkg::CSR_RIE]) rxirq_d = 1'b1;
            if (alarm_d > ALARM_LIM) begin
              csr_d[smli_pkg::CSR_SA] = 1'b1;
              if (csr_q[smli_pkg::CSR_SAE]) rxirq_d = 1'b1;
            end
          end
        end
        smli_pkg::REQ_CONN: begin
          if (conn_in_q) begin
            conn_d[ln_q] = 1'b1;
            ring_d[ln_q] = 1'b1;
            hflag_d[ln_q] = 1'b0;
          end else begin
            conn_d[ln_q] = 1'b0;
          end
        end
        smli_pkg::REQ_RETRY: begin
          if (hflag_q[ln_q] && conn_q[ln_q] && rdy_q) begin
            txv_d = 1'b1; txl_d = ln_q; txc_d = hsel;
            hflag_d[ln_q] = 1'b0;
          end
        end
        default: scan_d = 1'b0;
      endcase
    end

    // rotating transmit scan, starting after the current TLINE
    if (cmd_i.scan && scan_q && csr_q[smli_pkg::CSR_MSE] && !csr_q[smli_pkg::CSR_TRDY]) begin
      start = csr_q[smli_pkg::CSR_THI:smli_pkg::CSR_TLO];
      for (int k = 1; k <= 8; k++) begin
        l = start + 3'(k);
        if (!found && len_q[l] && !hflag_q[l]) begin
          found = 1'b1;
          pick = l;
        end
      end
      if (found) begin
        csr_d[smli_pkg::CSR_THI:smli_pkg::CSR_TLO] = pick;
        csr_d[smli_pkg::CSR_TRDY] = 1'b1;
        if (csr_q[smli_pkg::CSR_TIE]) txirq_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i.req_type;     off_q <= req_i.reg_offset;
      bytew_q <= req_i.byte_access; data_q <= req_i.write_data;
      ln_q <= req_i.line_number;   ch_q <= req_i.rx_char;
      brk_q <= req_i.rx_break;     conn_in_q <= req_i.line_connected;
      rdy_q <= req_i.link_ready;
    end
    if (hwe) hchar_q[csr_q[smli_pkg::CSR_THI:smli_pkg::CSR_TLO]] <= data_q[7:0];
    rd_d_to_q: begin
      rd_q <= rd_d; txv_q <= txv_d; txl_q <= txl_d; txc_q <= txc_d;
      acc_q <= acc_d; scan_q <= scan_d;
    end
    if (cmd_i.load) begin
      rsp_o.read_data <= rd_q;   rsp_o.tx_valid <= txv_q;
      rsp_o.tx_line <= txl_q;    rsp_o.tx_char <= txc_q;
      rsp_o.rx_accepted <= acc_q; rsp_o.rx_irq <= rxirq_q;
      rsp_o.tx_irq <= txirq_q;   rsp_o.dtr_lines <= dtr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      csr_q <= '0; wp_q <= '0; rp_q <= '0; alarm_q <= '0;
      len_q <= '0; dtr_q <= '0; rxon_q <= '0; ring_q <= '0; conn_q <= '0;
      hflag_q <= '0; rxirq_q <= 1'b0; txirq_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      csr_q <= csr_d; wp_q <= wp_d; rp_q <= rp_d; alarm_q <= alarm_d;
      len_q <= len_d; dtr_q <= dtr_d; rxon_q <= rxon_d; ring_q <= ring_d; conn_q <= conn_d;
      hflag_q <= hflag_d; rxirq_q <= rxirq_d; txirq_q <= txirq_d;
      if (cmd_i.load) out_valid_q <= 1'b1;
      else if (rsp_o.ready) out_valid_q <= 1'b0;
    end
  end

  assign rsp_o.valid = out_valid_q;
endmodule

// ===== rtl/serial_mux_line_interface_top.sv =====
// Top level of the eight-line serial multiplexer unit.
// Depends on smli_pkg, smli_if, smli_ctrl, smli_dp and smli_ram.
//
//  port    role    carries
//  req_i   sink    bus read/write, received character, connection change, retry
//  rsp_o   source  read data, sent character, receive status, irq levels, DTR
//
// The accepting edge captures the request; silo read (registered RAM port),
// execute, transmit line scan and deliver follow as sequencer states, and the
// response is loaded in the deliver step. The registered silo RAM read and the
// scan after the state update each take a step of their own. A new request is
// taken in the cycle after the response is loaded, so no request is taken while
// one is in progress; a stalled response holds the sequencer in its deliver step.
// Reset is asynchronous, active low; it clears all control state and held-character
// flags at once, with no clearing pass. Silo contents and held characters are not reset.
module serial_mux_line_interface_top #(
  parameter int unsigned SILO_DEPTH  = 64,
  parameter int unsigned ALARM_LEVEL = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  smli_req_if.sink   req_i,
  smli_rsp_if.source rsp_o
);
  smli_pkg::cmd_t cmd;
  smli_pkg::sts_t sts;
  logic           ready;

  smli_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  smli_dp #(.SILO_DEPTH(SILO_DEPTH), .ALARM_LEVEL(ALARM_LEVEL)) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

  // sequencer idle means the request channel is open
  assign req_i.ready = ready;

  // accepted transaction keeps the sequencer busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready) else $error("accepted while busy");

  // no character shown without tx_valid
  a_tx_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.tx_valid) |-> (rsp_o.tx_line == 3'd0 && rsp_o.tx_char == 8'd0))
    else $error("tx fields set without tx_valid");

  // a stored character never comes with read data or a sent character
  a_rx_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.rx_accepted) |-> (rsp_o.read_data == 16'd0 && !rsp_o.tx_valid))
    else $error("receive result mixed with read or send");
endmodule
